[rtl/firmware_push_handshake_controller_assert.svh]
// Assertion macros used by the top level of the firmware push controller.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef FIRMWARE_PUSH_HANDSHAKE_CONTROLLER_ASSERT_SVH
`define FIRMWARE_PUSH_HANDSHAKE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define FPHC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside of reset.
`define FPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/fphc_pkg.sv]
// Types and codes for the firmware push controller.
// Used by fphc_cfg, fphc_seq and the top level; depends on nothing.
package fphc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_SCHED_EN   = 3'd0;
	localparam logic [2:0] REG_SCHED_HOUR = 3'd1;
	localparam logic [2:0] REG_FW_SIZE    = 3'd2;
	localparam logic [2:0] REG_WAIT_TICKS = 3'd3;
	localparam logic [2:0] REG_RETRY_LIM  = 3'd4;
	localparam logic [2:0] REG_CRC_LIM    = 3'd5;

	// Command codes.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	// Acknowledgement kinds.
	localparam logic [1:0] ACK_HS    = 2'd0;
	localparam logic [1:0] ACK_DATA  = 2'd1;
	localparam logic [1:0] ACK_FIN   = 2'd2;

	// Partner result codes.
	localparam logic [7:0] RES_OK      = 8'd0;
	localparam logic [7:0] RES_CRC_ERR = 8'd1;

	// Actions.
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_HS    = 3'd1;
	localparam logic [2:0] ACT_DATA  = 3'd2;
	localparam logic [2:0] ACT_FIN   = 3'd3;
	localparam logic [2:0] ACT_ENDED = 3'd4;

	// End reasons.
	localparam logic [3:0] END_SUCCESS    = 4'd0;
	localparam logic [3:0] END_START_FAIL = 4'd1;
	localparam logic [3:0] END_HS_CRC     = 4'd2;
	localparam logic [3:0] END_HS_REFUSED = 4'd3;
	localparam logic [3:0] END_DATA_CRC   = 4'd4;
	localparam logic [3:0] END_DATA_ABORT = 4'd5;
	localparam logic [3:0] END_HS_TMO     = 4'd6;
	localparam logic [3:0] END_DATA_TMO   = 4'd7;
	localparam logic [3:0] END_FIN_TMO    = 4'd8;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CRC_REJ   = 2'd1;
	localparam logic [1:0] ST_SHORT_IMG = 2'd2;

	// A data ack carrying this CRC is accepted even on a CRC mismatch.
	localparam logic [15:0] CRC_BYPASS = 16'h40BF;

	localparam logic [7:0] TICK_MAX = 8'hFF;
	localparam logic [1:0] CNT_MAX  = 2'd3;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_HS        = 7'b0000010,
		PH_HS_WAIT   = 7'b0000100,
		PH_DATA      = 7'b0001000,
		PH_DATA_WAIT = 7'b0010000,
		PH_FIN       = 7'b0100000,
		PH_FIN_WAIT  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic        command;
		logic [4:0]  hour_now;
		logic        firmware_ready;
		logic [1:0]  ack_kind;
		logic        crc_match;
		logic [15:0] recv_crc;
		logic [15:0] req_frame;
		logic [15:0] last_frame;
		logic [7:0]  result_code;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] frame_number;
		logic [23:0] chunk_offset;
		logic [7:0]  chunk_length;
		logic [3:0]  end_reason;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic [4:0]  sched_hour;
		logic [23:0] fw_size;
		logic [7:0]  wait_ticks;
		logic [1:0]  retry_limit;
		logic [1:0]  crc_limit;
	} cfg_t;

	// Write of the enable register also reloads the armed flag.
	typedef struct packed {
		logic valid;
		logic value;
	} arm_wr_t;

endpackage

[rtl/fphc_cfg.sv]
// Configuration register file of the firmware push controller.
// Depends on fphc_pkg for register indexes and the configuration struct.
module fphc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [23:0]       wr_data,
	output fphc_pkg::cfg_t    cfg,
	output fphc_pkg::arm_wr_t arm_wr
);
	import fphc_pkg::*;

	logic        sched_en_q;
	logic [4:0]  sched_hour_q;
	logic [23:0] fw_size_q;
	logic [7:0]  wait_ticks_q;
	logic [1:0]  retry_lim_q;
	logic [1:0]  crc_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_en_q   <= 1'b0;
			sched_hour_q <= 5'd0;
			fw_size_q    <= 24'd1;
			wait_ticks_q <= 8'd10;
			retry_lim_q  <= 2'd3;
			crc_lim_q    <= 2'd3;
		end else if (wr_en) begin
			case (wr_index)
				REG_SCHED_EN:   sched_en_q   <= wr_data[0];
				REG_SCHED_HOUR: sched_hour_q <= wr_data[4:0];
				REG_FW_SIZE:    fw_size_q    <= wr_data;
				REG_WAIT_TICKS: wait_ticks_q <= wr_data[7:0];
				REG_RETRY_LIM:  retry_lim_q  <= wr_data[1:0];
				REG_CRC_LIM:    crc_lim_q    <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sched_hour  = sched_hour_q;
	assign cfg.fw_size     = fw_size_q;
	assign cfg.wait_ticks  = wait_ticks_q;
	assign cfg.retry_limit = retry_lim_q;
	assign cfg.crc_limit   = crc_lim_q;

	// The armed flag follows the written enable value directly.
	assign arm_wr.valid = wr_en && (wr_index == REG_SCHED_EN);
	assign arm_wr.value = (wr_index == REG_SCHED_EN) ? wr_data[0] : sched_en_q;

endmodule

[rtl/fphc_seq.sv]
// Phase sequencer of the firmware push controller: state registers and the
// combinational next-state and result logic. Depends on fphc_pkg.
module fphc_seq #(
	parameter int CHUNK_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  fphc_pkg::item_t   item,
	input  fphc_pkg::cfg_t    cfg,
	input  fphc_pkg::arm_wr_t arm_wr,
	output fphc_pkg::result_t res,
	output fphc_pkg::phase_t  phase
);
	import fphc_pkg::*;

	localparam logic [24:0] CHUNK_W   = 25'(CHUNK_BYTES);
	localparam logic [7:0]  CHUNK_LEN = 8'(CHUNK_BYTES);

	phase_t      phase_q, nxt_phase;
	logic [7:0]  tick_q, nxt_tick, tick_inc;
	logic [1:0]  retry_q, nxt_retry, retry_inc;
	logic [1:0]  crc_q, nxt_crc, crc_inc;
	logic [24:0] br_q, nxt_br;
	logic [7:0]  len_q, nxt_len;
	logic [15:0] frame_q, nxt_frame;
	logic        armed_q, nxt_armed;

	logic        emit;
	logic        crc_reject;
	logic [24:0] size_w;
	logic [24:0] left;
	logic [24:0] len_sel;
	logic [16:0] cur_next;

	always_comb begin
		nxt_phase = phase_q;
		nxt_tick  = tick_q;
		nxt_retry = retry_q;
		nxt_crc   = crc_q;
		nxt_br    = br_q;
		nxt_len   = len_q;
		nxt_frame = frame_q;
		nxt_armed = armed_q;
		res       = '0;
		emit      = 1'b0;

		tick_inc  = (tick_q == TICK_MAX) ? tick_q : tick_q + 8'd1;
		retry_inc = (retry_q == CNT_MAX) ? retry_q : retry_q + 2'd1;
		crc_inc   = (crc_q == CNT_MAX) ? crc_q : crc_q + 2'd1;

		size_w     = {1'b0, cfg.fw_size};
		left       = size_w - br_q;
		len_sel    = (left >= CHUNK_W) ? CHUNK_W : left;
		cur_next   = {1'b0, item.last_frame} + 17'd1;
		crc_reject = !item.crc_match &&
			!(item.ack_kind == ACK_DATA && item.recv_crc == CRC_BYPASS);

		if (item.command == CMD_TICK) begin
			nxt_tick = tick_inc;
			case (phase_q)
				PH_IDLE: begin
					if (armed_q && item.hour_now == cfg.sched_hour) begin
						if (item.firmware_ready) begin
							nxt_br    = '0;
							nxt_frame = '0;
							nxt_retry = '0;
							nxt_crc   = '0;
							nxt_phase = PH_HS;
							nxt_tick  = '0;
						end else begin
							res.action     = ACT_ENDED;
							res.end_reason = END_START_FAIL;
						end
					end
				end
				PH_HS: begin
					res.action = ACT_HS;
					nxt_phase  = PH_HS_WAIT;
					nxt_tick   = '0;
				end
				PH_DATA: begin
					emit      = 1'b1;
					nxt_phase = PH_DATA_WAIT;
					nxt_tick  = '0;
				end
				PH_FIN: begin
					res.action = ACT_FIN;
					nxt_phase  = PH_FIN_WAIT;
					nxt_tick   = '0;
				end
				PH_HS_WAIT, PH_DATA_WAIT, PH_FIN_WAIT: begin
					if (tick_inc > cfg.wait_ticks) begin
						nxt_retry = retry_inc;
						if (retry_inc >= cfg.retry_limit) begin
							res.action = ACT_ENDED;
							if (phase_q == PH_HS_WAIT)
								res.end_reason = END_HS_TMO;
							else if (phase_q == PH_DATA_WAIT)
								res.end_reason = END_DATA_TMO;
							else
								res.end_reason = END_FIN_TMO;
						end else begin
							nxt_tick = '0;
							if (phase_q == PH_HS_WAIT)
								nxt_phase = PH_HS;
							else if (phase_q == PH_DATA_WAIT)
								nxt_phase = PH_DATA;
							else
								nxt_phase = PH_FIN;
						end
					end
				end
				default: begin
					// An illegal phase code drops back to idle and still advances the tick count.
					nxt_phase = PH_IDLE;
				end
			endcase
		end else if (crc_reject) begin
			res.status = ST_CRC_REJ;
		end else begin
			case (item.ack_kind)
				ACK_HS: begin
					if (item.result_code == RES_OK) begin
						nxt_crc = '0;
						if (size_w >= CHUNK_W) begin
							nxt_br    = CHUNK_W;
							nxt_len   = CHUNK_LEN;
							nxt_frame = 16'd1;
							nxt_retry = '0;
							emit      = 1'b1;
							nxt_phase = PH_DATA_WAIT;
							nxt_tick  = '0;
						end else begin
							res.status = ST_SHORT_IMG;
						end
					end else if (item.result_code == RES_CRC_ERR) begin
						nxt_crc = crc_inc;
						if (crc_inc >= cfg.crc_limit) begin
							res.action     = ACT_ENDED;
							res.end_reason = END_HS_CRC;
						end else begin
							res.action = ACT_HS;
							nxt_phase  = PH_HS;
							nxt_tick   = '0;
						end
					end else begin
						res.action     = ACT_ENDED;
						res.end_reason = END_HS_REFUSED;
					end
				end
				ACK_DATA: begin
					if (item.result_code > RES_CRC_ERR) begin
						res.action     = ACT_ENDED;
						res.end_reason = END_DATA_ABORT;
					end else if (item.result_code == RES_CRC_ERR &&
							crc_inc >= cfg.crc_limit) begin
						nxt_crc        = crc_inc;
						res.action     = ACT_ENDED;
						res.end_reason = END_DATA_CRC;
					end else begin
						if (item.result_code == RES_CRC_ERR) begin
							nxt_crc = crc_inc;
						end else begin
							nxt_crc   = '0;
							nxt_retry = '0;
						end
						if (item.req_frame == item.last_frame) begin
							emit = 1'b1;
						end else if ({1'b0, item.req_frame} == cur_next) begin
							if (br_q < size_w) begin
								nxt_len   = len_sel[7:0];
								nxt_br    = br_q + CHUNK_W;
								nxt_frame = frame_q + 16'd1;
								emit      = 1'b1;
								nxt_phase = PH_DATA_WAIT;
								nxt_tick  = '0;
							end else begin
								res.action = ACT_FIN;
								nxt_retry  = '0;
								nxt_phase  = PH_FIN;
								nxt_tick   = '0;
							end
						end
					end
				end
				ACK_FIN: begin
					res.action     = ACT_ENDED;
					res.end_reason = END_SUCCESS;
				end
				default: ;
			endcase
		end

		// Any end of the upgrade disarms the schedule and returns to idle.
		if (res.action == ACT_ENDED) begin
			nxt_armed = 1'b0;
			nxt_phase = PH_IDLE;
			nxt_tick  = '0;
		end

		if (emit) begin
			res.action       = ACT_DATA;
			res.frame_number = nxt_frame;
			res.chunk_offset = 24'(nxt_br - CHUNK_W);
			res.chunk_length = nxt_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			retry_q <= '0;
			crc_q   <= '0;
			br_q    <= '0;
			len_q   <= '0;
			frame_q <= '0;
			armed_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= nxt_phase;
				tick_q  <= nxt_tick;
				retry_q <= nxt_retry;
				crc_q   <= nxt_crc;
				br_q    <= nxt_br;
				len_q   <= nxt_len;
				frame_q <= nxt_frame;
			end
			if (arm_wr.valid)
				armed_q <= arm_wr.value;
			else if (fire)
				armed_q <= nxt_armed;
		end
	end

	assign phase = phase_q;

endmodule

[rtl/firmware_push_handshake_controller.sv]
// Channel | handshake             | payload
// in      | in_valid / in_ready   | command, hour_now, firmware_ready, ack_kind, crc_match,
//         |                       | recv_crc, req_frame, last_frame, result_code
// out     | out_valid / out_ready | action, frame_number, chunk_offset, chunk_length,
//         |                       | end_reason, status
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each transaction passes through the input register, then the result register, which
// the sequencer loads in the same pass as it updates its state.
// One transaction is accepted per cycle unless the output stalls; the sequencer's state loop sets the rate.
// A stalled output holds the result register, which holds the input register in turn.
// Reset puts the phase in idle, clears all counters and disarms the schedule.
// Top level of the firmware push controller; depends on fphc_pkg, fphc_cfg, fphc_seq
// and the assertion macro header.
module firmware_push_handshake_controller #(
	parameter int CHUNK_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [4:0]  hour_now,
	input  logic        firmware_ready,
	input  logic [1:0]  ack_kind,
	input  logic        crc_match,
	input  logic [15:0] recv_crc,
	input  logic [15:0] req_frame,
	input  logic [15:0] last_frame,
	input  logic [7:0]  result_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [15:0] frame_number,
	output logic [23:0] chunk_offset,
	output logic [7:0]  chunk_length,
	output logic [3:0]  end_reason,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import fphc_pkg::*;
	`include "firmware_push_handshake_controller_assert.svh"

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	cfg_t    cfg;
	arm_wr_t arm_wr;
	phase_t  phase;

	assign cfg_ready = 1'b1;

	// The input stage moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command        <= command;
			item_s1.hour_now       <= hour_now;
			item_s1.firmware_ready <= firmware_ready;
			item_s1.ack_kind       <= ack_kind;
			item_s1.crc_match      <= crc_match;
			item_s1.recv_crc       <= recv_crc;
			item_s1.req_frame      <= req_frame;
			item_s1.last_frame     <= last_frame;
			item_s1.result_code    <= result_code;
		end
	end

	fphc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.arm_wr   (arm_wr)
	);

	fphc_seq #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.arm_wr (arm_wr),
		.res    (res_next),
		.phase  (phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_next;
	end

	assign out_valid    = out_valid_q;
	assign action       = res_q.action;
	assign frame_number = res_q.frame_number;
	assign chunk_offset = res_q.chunk_offset;
	assign chunk_length = res_q.chunk_length;
	assign end_reason   = res_q.end_reason;
	assign status       = res_q.status;

	`FPHC_ASSERT_NEXT(a_end_goes_idle, clk, arst_n,
		advance && res_next.action == ACT_ENDED, phase == PH_IDLE)
	`FPHC_ASSERT_IMPLY(a_reason_only_on_end, clk, arst_n,
		out_valid && end_reason != END_SUCCESS, action == ACT_ENDED)
	`FPHC_ASSERT_IMPLY(a_chunk_only_on_data, clk, arst_n,
		out_valid && action != ACT_DATA,
		frame_number == 16'd0 && chunk_offset == 24'd0 && chunk_length == 8'd0)
	`FPHC_ASSERT_NEXT(a_stall_holds_stage, clk, arst_n,
		valid_s1 && out_valid_q && !out_ready, valid_s1 && $stable(item_s1))

endmodule

[tb/sv/fphc_action_checker.sv]
`timescale 1ns / 100ps
// Checker for the firmware push controller: watches the input, result and register channels,
// predicts the action for every accepted transaction and compares results field by field.
// Depends on fphc_pkg for the item, result and code definitions.
module fphc_action_checker
	import fphc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        command,
	input  logic [4:0]  hour_now,
	input  logic        firmware_ready,
	input  logic [1:0]  ack_kind,
	input  logic        crc_match,
	input  logic [15:0] recv_crc,
	input  logic [15:0] req_frame,
	input  logic [15:0] last_frame,
	input  logic [7:0]  result_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  action,
	input  logic [15:0] frame_number,
	input  logic [23:0] chunk_offset,
	input  logic [7:0]  chunk_length,
	input  logic [3:0]  end_reason,
	input  logic [1:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          failures,
	output int          outstanding
);

	localparam logic [24:0] CHUNK_SPAN = 25'd128;
	localparam logic [23:0] CHUNK_MIN_IMAGE = 24'd128;
	localparam logic [7:0]  CHUNK_FULL = 8'd128;

	// Register copies.
	logic [4:0]  sched_hour;
	logic [23:0] image_size;
	logic [7:0]  wait_limit;
	logic [1:0]  retry_limit;
	logic [1:0]  crc_limit;

	// Sequencer state.
	phase_t      phase;
	logic [7:0]  ticks;
	logic [1:0]  retries;
	logic [1:0]  crc_errors;
	logic [24:0] bytes_sent;
	logic [7:0]  chunk_len;
	logic [15:0] frame_no;
	logic        armed;

	result_t expected_actions[$];

	task automatic enter_phase(input phase_t p);
		phase = p;
		ticks = '0;
	endtask

	task automatic end_upgrade(inout result_t r, input logic [3:0] why);
		armed = 1'b0;
		enter_phase(PH_IDLE);
		r.action = ACT_ENDED;
		r.end_reason = why;
	endtask

	task automatic send_chunk(inout result_t r);
		logic [24:0] start;
		start = bytes_sent - CHUNK_SPAN;
		r.action = ACT_DATA;
		r.frame_number = frame_no;
		r.chunk_offset = start[23:0];
		r.chunk_length = chunk_len;
	endtask

	task automatic count_crc_error(output logic at_limit);
		if (crc_errors < CNT_MAX)
			crc_errors++;
		at_limit = (crc_errors >= crc_limit);
	endtask

	task automatic check_wait(inout result_t r, input phase_t resend, input logic [3:0] why);
		if (ticks > wait_limit) begin
			if (retries < CNT_MAX)
				retries++;
			if (retries >= retry_limit)
				end_upgrade(r, why);
			else
				enter_phase(resend);
		end
	endtask

	task automatic on_tick(input item_t ev, inout result_t r);
		if (ticks != TICK_MAX)
			ticks++;
		case (phase)
			PH_IDLE: begin
				if (armed && ev.hour_now == sched_hour) begin
					if (ev.firmware_ready) begin
						bytes_sent = '0;
						frame_no = '0;
						retries = '0;
						crc_errors = '0;
						enter_phase(PH_HS);
					end else
						end_upgrade(r, END_START_FAIL);
				end
			end
			PH_HS: begin
				r.action = ACT_HS;
				enter_phase(PH_HS_WAIT);
			end
			PH_HS_WAIT: check_wait(r, PH_HS, END_HS_TMO);
			PH_DATA: begin
				send_chunk(r);
				enter_phase(PH_DATA_WAIT);
			end
			PH_DATA_WAIT: check_wait(r, PH_DATA, END_DATA_TMO);
			PH_FIN: begin
				r.action = ACT_FIN;
				enter_phase(PH_FIN_WAIT);
			end
			PH_FIN_WAIT: check_wait(r, PH_FIN, END_FIN_TMO);
			default: phase = PH_IDLE;
		endcase
	endtask

	task automatic on_ack(input item_t ev, inout result_t r);
		logic        at_limit;
		logic [23:0] left;
		at_limit = 1'b0;
		// A data ack carrying the bypass CRC gets through a CRC mismatch.
		if (!ev.crc_match && !(ev.ack_kind == ACK_DATA && ev.recv_crc == CRC_BYPASS)) begin
			r.status = ST_CRC_REJ;
		end else if (ev.ack_kind == ACK_HS) begin
			if (ev.result_code == RES_OK) begin
				crc_errors = '0;
				if (image_size >= CHUNK_MIN_IMAGE) begin
					bytes_sent = CHUNK_SPAN;
					chunk_len = CHUNK_FULL;
					frame_no = 16'd1;
					send_chunk(r);
					retries = '0;
					enter_phase(PH_DATA_WAIT);
				end else
					r.status = ST_SHORT_IMG;
			end else if (ev.result_code == RES_CRC_ERR) begin
				count_crc_error(at_limit);
				if (at_limit)
					end_upgrade(r, END_HS_CRC);
				else begin
					r.action = ACT_HS;
					enter_phase(PH_HS);
				end
			end else
				end_upgrade(r, END_HS_REFUSED);
		end else if (ev.ack_kind == ACK_DATA) begin
			if (ev.result_code > RES_CRC_ERR) begin
				end_upgrade(r, END_DATA_ABORT);
			end else begin
				if (ev.result_code == RES_CRC_ERR)
					count_crc_error(at_limit);
				else begin
					crc_errors = '0;
					retries = '0;
				end
				if (at_limit)
					end_upgrade(r, END_DATA_CRC);
				else if (ev.req_frame == ev.last_frame)
					send_chunk(r);
				else if ({1'b0, ev.req_frame} == {1'b0, ev.last_frame} + 17'd1) begin
					if (bytes_sent < {1'b0, image_size}) begin
						left = image_size - bytes_sent[23:0];
						chunk_len = (left >= CHUNK_MIN_IMAGE) ? CHUNK_FULL : left[7:0];
						bytes_sent = bytes_sent + CHUNK_SPAN;
						frame_no = frame_no + 16'd1;
						send_chunk(r);
						enter_phase(PH_DATA_WAIT);
					end else begin
						r.action = ACT_FIN;
						retries = '0;
						enter_phase(PH_FIN);
					end
				end
			end
		end else if (ev.ack_kind == ACK_FIN) begin
			end_upgrade(r, END_SUCCESS);
		end
	endtask

	task automatic predict_action(input item_t ev, output result_t r);
		r = '0;
		if (ev.command == CMD_ACK)
			on_ack(ev, r);
		else
			on_tick(ev, r);
	endtask

	task automatic apply_write(input logic [2:0] idx, input logic [23:0] val);
		case (idx)
			REG_SCHED_EN: armed = val[0];
			REG_SCHED_HOUR: sched_hour = val[4:0];
			REG_FW_SIZE: image_size = val;
			REG_WAIT_TICKS: wait_limit = val[7:0];
			REG_RETRY_LIM: retry_limit = val[1:0];
			REG_CRC_LIM: crc_limit = val[1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   ev;
		result_t want;
		result_t got;
		if (!arst_n) begin
			sched_hour = '0;
			image_size = 24'd1;
			wait_limit = 8'd10;
			retry_limit = 2'd3;
			crc_limit = 2'd3;
			armed = 1'b0;
			phase = PH_IDLE;
			ticks = '0;
			retries = '0;
			crc_errors = '0;
			bytes_sent = '0;
			chunk_len = '0;
			frame_no = '0;
			expected_actions.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				ev = {command, hour_now, firmware_ready, ack_kind, crc_match, recv_crc,
					req_frame, last_frame, result_code};
				predict_action(ev, want);
				expected_actions.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = {action, frame_number, chunk_offset, chunk_length, end_reason, status};
				if (expected_actions.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result with no transaction pending: act %0d end %0d st %0d",
							$time, got.action, got.end_reason, got.status);
				end else begin
					want = expected_actions.pop_front();
					if (want.action !== got.action || want.frame_number !== got.frame_number ||
						want.chunk_offset !== got.chunk_offset ||
						want.chunk_length !== got.chunk_length ||
						want.end_reason !== got.end_reason || want.status !== got.status) begin
						failures++;
						if (failures <= 10)
							$display({"%0t: mismatch: expected act %0d frame %0d off %0d len %0d",
								" end %0d st %0d, got act %0d frame %0d off %0d len %0d end %0d st %0d"},
								$time, want.action, want.frame_number, want.chunk_offset,
								want.chunk_length, want.end_reason, want.status, got.action,
								got.frame_number, got.chunk_offset, got.chunk_length,
								got.end_reason, got.status);
					end
				end
			end
			outstanding = expected_actions.size();
		end
	end

endmodule

[tb/sv/tb_firmware_push_handshake_controller.sv]
`timescale 1ns / 100ps
// Top of the firmware push controller testbench: clock, reset, register setup, directed
// and random transactions with random idling, and the verdict.
// Depends on fphc_pkg, the controller RTL and fphc_action_checker.
module tb_firmware_push_handshake_controller;
	import fphc_pkg::*;

	localparam logic [1:0] ACK_OTHER   = 2'd3;
	localparam logic [7:0] RES_REFUSED = 8'd2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [4:0]  hour_now;
	logic        firmware_ready;
	logic [1:0]  ack_kind;
	logic        crc_match;
	logic [15:0] recv_crc;
	logic [15:0] req_frame;
	logic [15:0] last_frame;
	logic [7:0]  result_code;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  action;
	logic [15:0] frame_number;
	logic [23:0] chunk_offset;
	logic [7:0]  chunk_length;
	logic [3:0]  end_reason;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          failures;
	int          outstanding;

	item_t       offer;
	int          snd_idle = 0;
	int          rcv_idle = 0;
	int          items_sent = 0;
	int          long_hold_at = 32'h7fffffff;
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;
	logic [4:0]  sched_hr;
	logic [23:0] img_size;
	logic [7:0]  wait_cfg;

	assign {command, hour_now, firmware_ready, ack_kind, crc_match, recv_crc, req_frame,
		last_frame, result_code} = offer;

	firmware_push_handshake_controller uut (.*);
	fphc_action_checker u_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off while the sender keeps going.
	always @(negedge clk) begin
		if (!long_hold_done && items_sent >= long_hold_at) begin
			long_hold_done = 1'b1;
			hold_left = 90;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	function automatic logic [4:0] rand_hour();
		return 5'($urandom_range(0, 23));
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.command = 1'($urandom_range(0, 1));
		it.hour_now = rand_hour();
		it.firmware_ready = 1'($urandom_range(0, 1));
		it.ack_kind = 2'($urandom_range(0, 3));
		it.crc_match = 1'($urandom_range(0, 1));
		it.recv_crc = 16'($urandom_range(0, 65535));
		it.req_frame = 16'($urandom_range(0, 65535));
		it.last_frame = 16'($urandom_range(0, 65535));
		it.result_code = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic item_t tick_at(input logic [4:0] hour, input logic ready);
		item_t it;
		it = noise_item();
		it.command = CMD_TICK;
		it.hour_now = hour;
		it.firmware_ready = ready;
		return it;
	endfunction

	function automatic item_t ack_of(input logic [1:0] kind, input logic crc_ok,
		input logic [15:0] req, input logic [15:0] cur, input logic [7:0] res);
		item_t it;
		it = noise_item();
		it.command = CMD_ACK;
		it.ack_kind = kind;
		it.crc_match = crc_ok;
		it.req_frame = req;
		it.last_frame = cur;
		it.result_code = res;
		return it;
	endfunction

	task automatic push_item(input item_t it);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		offer <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no lowering in between.
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic en, input logic [4:0] hour, input logic [23:0] size,
		input logic [7:0] wait_n, input logic [1:0] retry_n, input logic [1:0] crc_n);
		drain();
		write_reg(REG_SCHED_HOUR, {19'd0, hour});
		write_reg(REG_FW_SIZE, size);
		write_reg(REG_WAIT_TICKS, {16'd0, wait_n});
		write_reg(REG_RETRY_LIM, {22'd0, retry_n});
		write_reg(REG_CRC_LIM, {22'd0, crc_n});
		write_reg(REG_SCHED_EN, {23'd0, en});
		cfg_valid <= 1'b0;
		sched_hr = hour;
		img_size = size;
		wait_cfg = wait_n;
	endtask

	task automatic tick_run();
		int n;
		if ($urandom_range(0, 3) == 0 && wait_cfg < 16)
			n = wait_cfg + 2;
		else
			n = $urandom_range(1, 3);
		repeat (n) push_item(tick_at(rand_hour(), 1'($urandom_range(0, 1))));
	endtask

	// One upgrade attempt: optional timed start, handshake, chunks with faults mixed in,
	// then finish, a stray ack, a refusing ack or a run of ticks.
	task automatic random_session();
		logic [15:0] sn;
		item_t       it;
		int          steps;
		int          pick;
		sn = 16'($urandom_range(0, 65534));
		if ($urandom_range(0, 2) == 0) begin
			push_item(tick_at(sched_hr, $urandom_range(0, 9) != 0));
			push_item(tick_at(rand_hour(), 1'($urandom_range(0, 1))));
		end
		if ($urandom_range(0, 5) == 0)
			tick_run();
		if ($urandom_range(0, 5) == 0)
			push_item(ack_of(ACK_HS, 1'b1, sn, sn, RES_CRC_ERR));
		push_item(ack_of(ACK_HS, $urandom_range(0, 15) != 0, sn, sn, RES_OK));
		steps = (img_size + 127) / 128;
		if (steps > 12)
			steps = 12;
		steps += $urandom_range(0, 2);
		repeat (steps) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				push_item(ack_of(ACK_DATA, 1'b1, sn + 16'd1, sn, RES_OK));
				sn++;
			end else if (pick < 68)
				push_item(ack_of(ACK_DATA, 1'b1, sn, sn, RES_OK));
			else if (pick < 74)
				push_item(ack_of(ACK_DATA, 1'b1, sn, sn, RES_CRC_ERR));
			else if (pick < 78)
				push_item(ack_of(ACK_DATA, 1'b0, sn + 16'd1, sn, RES_OK));
			else if (pick < 82) begin
				it = ack_of(ACK_DATA, 1'b0, sn + 16'd1, sn, RES_OK);
				it.recv_crc = CRC_BYPASS;
				push_item(it);
				sn++;
			end else if (pick < 92)
				tick_run();
			else
				push_item(noise_item());
		end
		repeat ($urandom_range(0, 2)) push_item(tick_at(rand_hour(), 1'b1));
		pick = $urandom_range(0, 9);
		if (pick < 7)
			push_item(ack_of(ACK_FIN, $urandom_range(0, 9) != 0, sn, sn, RES_OK));
		else if (pick < 8)
			push_item(ack_of(ACK_OTHER, 1'b1, sn, sn, RES_OK));
		else if (pick < 9)
			push_item(ack_of($urandom_range(0, 1) ? ACK_HS : ACK_DATA, 1'b1, sn, sn,
				8'($urandom_range(RES_REFUSED, 255))));
		else begin
			tick_run();
			tick_run();
			tick_run();
		end
	endtask

	task automatic random_phase(input int quota);
		int target;
		target = items_sent + quota;
		while (items_sent < target)
			random_session();
	endtask

	initial begin
		item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		offer = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sched_hr = '0;
		img_size = 24'd1;
		wait_cfg = 8'd10;
		snd_idle = 16;
		rcv_idle = 88;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: a one-byte image is shorter than a chunk, the schedule is disarmed.
		push_item(ack_of(ACK_HS, 1'b1, 16'd0, 16'd0, RES_OK));
		push_item(tick_at(5'd0, 1'b1));

		configure(1'b1, 5'd5, 24'd300, 8'd1, 2'd2, 2'd2);
		push_item(tick_at(5'd4, 1'b1));
		push_item(tick_at(5'd5, 1'b0));
		push_item(tick_at(5'd5, 1'b1));
		push_item(ack_of(ACK_HS, 1'b0, 16'd0, 16'd0, RES_OK));
		push_item(ack_of(ACK_HS, 1'b1, 16'd0, 16'd0, RES_CRC_ERR));
		push_item(tick_at(5'd23, 1'b0));
		push_item(ack_of(ACK_HS, 1'b1, 16'hFFFF, 16'd0, RES_OK));
		it = ack_of(ACK_DATA, 1'b0, 16'd7, 16'd7, RES_OK);
		it.recv_crc = CRC_BYPASS;
		push_item(it);
		push_item(ack_of(ACK_DATA, 1'b1, 16'd8, 16'd7, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd9, 16'd8, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd20, 16'd9, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd0, 16'hFFFF, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd10, 16'd9, RES_OK));
		// Finish is resent after a timeout; the second timeout ends the upgrade.
		repeat (7) push_item(tick_at(rand_hour(), 1'b1));
		push_item(ack_of(ACK_OTHER, 1'b1, 16'd0, 16'd0, RES_OK));
		push_item(ack_of(ACK_FIN, 1'b1, 16'd0, 16'd0, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd0, 16'd0, 8'hFF));
		push_item(ack_of(ACK_HS, 1'b1, 16'd0, 16'd0, 8'h80));
		push_item(ack_of(ACK_HS, 1'b1, 16'd0, 16'd0, RES_OK));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd3, 16'd3, RES_CRC_ERR));
		push_item(ack_of(ACK_DATA, 1'b1, 16'd3, 16'd3, RES_CRC_ERR));
		random_phase(110);

		configure(1'b1, 5'd23, 24'd1000, 8'd3, 2'd3, 2'd3);
		random_phase(130);

		// Longest wait: tick count saturates, so the wait never runs out.
		configure(1'b1, 5'd0, 24'hFFFFFF, 8'd255, 2'd1, 2'd1);
		push_item(ack_of(ACK_HS, 1'b1, 16'd0, 16'd0, RES_OK));
		repeat (300) push_item(tick_at(rand_hour(), 1'($urandom_range(0, 1))));
		random_phase(60);

		snd_idle = 88;
		rcv_idle = 16;
		// Limits of zero end the upgrade on the first retry or CRC error.
		configure(1'b0, 5'd12, 24'd128, 8'd2, 2'd0, 2'd0);
		random_phase(100);

		configure(1'b1, rand_hour(), 24'($urandom_range(1, 1500)), 8'($urandom_range(1, 4)),
			2'($urandom_range(1, 3)), 2'($urandom_range(1, 3)));
		random_phase(120);

		configure(1'b1, rand_hour(), 24'd1, 8'd1, 2'd3, 2'd2);
		random_phase(80);

		snd_idle = 0;
		rcv_idle = 0;
		configure(1'b1, rand_hour(), 24'($urandom_range(1, 2000)), 8'($urandom_range(1, 6)),
			2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)));
		long_hold_at = items_sent + 15;
		random_phase(140);

		configure(1'b1, rand_hour(), 24'($urandom_range(129, 900)), 8'($urandom_range(1, 3)),
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
		random_phase(140);

		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("firmware_push_handshake_controller verification clean");
		else
			$display("firmware_push_handshake_controller verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("firmware_push_handshake_controller verification failed");
		$finish;
	end

endmodule
